### sv/b64sc_pkg.sv
// ----------------------------------------------------------------------------
// b64sc_pkg
// shared types, codes and alphabet functions of the base64 stream codec
// ----------------------------------------------------------------------------
package b64sc_pkg;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam int         JOB_MAX  = 4;
  localparam int         CNT_W    = 3;

  // one queue entry: the results caused by one input item
  typedef struct packed {
    logic [JOB_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]        cnt;
    logic                    present;
    logic                    done;
  } job_t;

  // six-bit value to alphabet character
  function automatic logic [7:0] char_of(input logic [5:0] s);
    logic [7:0] v;
    v = {2'b00, s};
    if (s < 6'd26) begin
      char_of = v + 8'h41;
    end else if (s < 6'd52) begin
      char_of = v + 8'h47;
    end else if (s < 6'd62) begin
      char_of = v - 8'd4;
    end else if (s == 6'd62) begin
      char_of = 8'h2B;
    end else begin
      char_of = 8'h2F;
    end
  endfunction

  // character to six-bit value, bit 6 set for a character outside the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    sextet_of = 7'h40;
    if (c inside {[8'h41:8'h5A]}) begin
      v = c - 8'h41;
      sextet_of = {1'b0, v[5:0]};
    end else if (c inside {[8'h61:8'h7A]}) begin
      v = c - 8'h47;
      sextet_of = {1'b0, v[5:0]};
    end else if (c inside {[8'h30:8'h39]}) begin
      v = c + 8'd4;
      sextet_of = {1'b0, v[5:0]};
    end else if (c == 8'h2B) begin
      sextet_of = 7'd62;
    end else if (c == 8'h2F) begin
      sextet_of = 7'd63;
    end
  endfunction

endpackage

### sv/base64_stream_codec.sv
// ----------------------------------------------------------------------------
// base64_stream_codec
// streaming base64 encoder and decoder, mode set by a register
//
//   port group   | dir | carries
//   s_t*         | in  | data_in, data_present (tuser), end_of_message (tlast)
//   m_t*         | out | data_out, out_present/run_last (tuser), message_done (tlast)
//   p*           | cfg | mode register at byte address 0
//
// one input item accepted per cycle while the job queue has room; results
// leave at one per cycle while out_ready allows, set by the single output
// register. results pass the job queue, then the output register. reset
// clears mode, partial group, queue and output register. either side may
// stall without losing items; the queue holds two jobs
// ----------------------------------------------------------------------------
module base64_stream_codec import b64sc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_in
  input  logic [0:0]  s_tuser,   // data_present
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // data_out
  output logic [1:0]  m_tuser,   // out_present, run_last
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic cfg_wr;
  logic mode_val;
  logic push;
  job_t push_job;
  logic q_full;
  logic pop;
  logic head_valid;
  job_t head_job;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, mode_val} : 32'd0;

  b64sc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr         (cfg_wr),
    .cfg_mode       (pwdata[0]),
    .mode_val       (mode_val),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .data_in        (s_tdata),
    .data_present   (s_tuser[0]),
    .end_of_message (s_tlast),
    .push           (push),
    .push_job       (push_job),
    .q_full         (q_full)
  );

  b64sc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  b64sc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_job     (head_job),
    .pop          (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .data_out     (m_tdata),
    .out_present  (m_tuser[0]),
    .run_last     (m_tuser[1]),
    .message_done (m_tlast)
  );

endmodule

### sv/b64sc_front.sv
// ----------------------------------------------------------------------------
// b64sc_front
// takes input items, keeps partial group, turns full groups and ends into jobs
// ----------------------------------------------------------------------------
module b64sc_front import b64sc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr,
  input  logic       cfg_mode,
  output logic       mode_val,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_in,
  input  logic       data_present,
  input  logic       end_of_message,
  output logic       push,
  output job_t       push_job,
  input  logic       q_full
);

  mode_t       mode;
  logic [23:0] group_bits;
  logic [1:0]  group_fill;
  logic        decode_halted;

  logic [23:0] group_bits_next;
  logic [1:0]  group_fill_next;
  logic        decode_halted_next;
  logic [6:0]  sx;
  logic        accept;
  job_t        job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign mode_val = mode;
  assign sx       = sextet_of(data_in);

  always_comb begin
    group_bits_next    = group_bits;
    group_fill_next    = group_fill;
    decode_halted_next = decode_halted;
    job                = '0;
    job.present        = 1'b1;
    if (mode == MODE_ENCODE) begin
      if (data_present) begin
        group_bits_next = {group_bits[15:0], data_in};
        group_fill_next = group_fill + 2'd1;
        if (group_fill_next == 2'd3) begin
          job.bytes[0]    = char_of(group_bits_next[23:18]);
          job.bytes[1]    = char_of(group_bits_next[17:12]);
          job.bytes[2]    = char_of(group_bits_next[11:6]);
          job.bytes[3]    = char_of(group_bits_next[5:0]);
          job.cnt         = 3'd4;
          group_bits_next = '0;
          group_fill_next = 2'd0;
        end
      end
      if (end_of_message) begin
        if (group_fill_next == 2'd1) begin
          job.bytes[0] = char_of(group_bits_next[7:2]);
          job.bytes[1] = char_of({group_bits_next[1:0], 4'b0000});
          job.bytes[2] = PAD_CHAR;
          job.bytes[3] = PAD_CHAR;
          job.cnt      = 3'd4;
        end else if (group_fill_next == 2'd2) begin
          job.bytes[0] = char_of(group_bits_next[15:10]);
          job.bytes[1] = char_of(group_bits_next[9:4]);
          job.bytes[2] = char_of({group_bits_next[3:0], 2'b00});
          job.bytes[3] = PAD_CHAR;
          job.cnt      = 3'd4;
        end
      end
    end else begin
      if (data_present && !decode_halted) begin
        if (sx[6]) begin
          decode_halted_next = 1'b1;
        end else begin
          group_bits_next = {group_bits[17:0], sx[5:0]};
          group_fill_next = group_fill + 2'd1;
          if (group_fill_next == 2'd0) begin
            job.bytes[0]    = group_bits_next[23:16];
            job.bytes[1]    = group_bits_next[15:8];
            job.bytes[2]    = group_bits_next[7:0];
            job.cnt         = 3'd3;
            group_bits_next = '0;
          end
        end
      end
      if (end_of_message) begin
        if (group_fill_next == 2'd2) begin
          job.bytes[0] = group_bits_next[11:4];
          job.cnt      = 3'd1;
        end else if (group_fill_next == 2'd3) begin
          job.bytes[0] = group_bits_next[17:10];
          job.bytes[1] = group_bits_next[9:2];
          job.cnt      = 3'd2;
        end
      end
    end
    if (end_of_message) begin
      if (job.cnt == 3'd0) begin
        job.cnt     = 3'd1;
        job.present = 1'b0;
        job.bytes   = '0;
      end
      job.done           = 1'b1;
      group_bits_next    = '0;
      group_fill_next    = 2'd0;
      decode_halted_next = 1'b0;
    end
  end

  assign push     = accept && (job.cnt != 3'd0);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_ENCODE;
      group_bits    <= '0;
      group_fill    <= 2'd0;
      decode_halted <= 1'b0;
    end else if (cfg_wr) begin
      mode          <= mode_t'(cfg_mode);
      group_bits    <= '0;
      group_fill    <= 2'd0;
      decode_halted <= 1'b0;
    end else if (accept) begin
      group_bits    <= group_bits_next;
      group_fill    <= group_fill_next;
      decode_halted <= decode_halted_next;
    end
  end

endmodule

### sv/b64sc_queue.sv
// ----------------------------------------------------------------------------
// b64sc_queue
// two-entry job queue between the front and the back
// ----------------------------------------------------------------------------
module b64sc_queue import b64sc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_job   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/b64sc_back.sv
// ----------------------------------------------------------------------------
// b64sc_back
// walks the head job into the output register, one result a cycle while free
// ----------------------------------------------------------------------------
module b64sc_back import b64sc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  job_t       head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_out,
  output logic       out_present,
  output logic       run_last,
  output logic       message_done
);

  logic [1:0] idx;
  logic       load;
  logic       is_last;

  assign load    = head_valid && (!out_valid || out_ready);
  assign is_last = ({1'b0, idx} == head_job.cnt - 3'd1);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_out     <= head_job.bytes[idx];
      out_present  <= head_job.present;
      run_last     <= is_last;
      message_done <= is_last && head_job.done;
    end
  end

endmodule
